>>> rtl/fsge_pkg.sv
// ----------------------------------------------------------------------------
// Falling sand grid engine package
// Shared constants, codes and types of the falling sand grid engine.
// ----------------------------------------------------------------------------
package fsge_pkg;

  // Default grid size.
  localparam int GRID_COLS_DEF = 64;
  localparam int GRID_ROWS_DEF = 64;

  // Random bit generator.
  localparam int              RNG_W          = 16;
  localparam logic [RNG_W-1:0] RNG_SEED_RESET = 16'd44257;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_MATERIAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED    = 2'd2;

  localparam int BRUSH_W = 4;
  localparam logic [BRUSH_W-1:0] BRUSH_SIZE_RESET = 4'd2;

  // Cell materials.
  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_WALL  = 2'd1;
  localparam logic [1:0] CELL_SAND  = 2'd2;
  localparam logic [1:0] CELL_WATER = 2'd3;

  // Commands.
  localparam logic [1:0] CMD_PAINT = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam int COORD_W = 6;

  // Control of the random bit generator.
  typedef struct packed {
    logic             load;
    logic [RNG_W-1:0] seed;
    logic             draw;
  } rng_ctrl_t;

endpackage

>>> rtl/falling_sand_grid_engine.sv
// ----------------------------------------------------------------------------
// Falling sand grid engine
// Two-bank grid of two-bit cells with paint, step and read commands.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    command_i, col_i, row_i
// out       output     out_valid_o / out_ready_i  cell_material_o, was_read_o
// cfg       input      cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
// After reset a clearing pass writes all 2 * 2**(clog2(cols) + clog2(rows))
// entries of both banks (8192 for a 64 x 64 grid) to empty, one entry a
// cycle; no transfer is taken on the input channel meanwhile.
// One item is worked at a time and in_ready_o is high only in the idle state.
// A read fetches one cell; a paint visits each point of the square of side
// 2r+1 around the centre for radius r. A step copies the live bank (one cell
// a cycle), then sweeps every cell with the grid memory's read and write
// ports; a cell that stays is only read and checked, while sand and water
// try their candidate targets in turn. The result waits in an output
// register; a stalled output holds the next result in the done state until
// the register is free.
// ----------------------------------------------------------------------------
module falling_sand_grid_engine #(
  parameter int GRID_COLS = fsge_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = fsge_pkg::GRID_ROWS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        command_i,
  input  logic [fsge_pkg::COORD_W-1:0]      col_i,
  input  logic [fsge_pkg::COORD_W-1:0]      row_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        cell_material_o,
  output logic                              was_read_o,
  input  logic                              cfg_we_i,
  input  logic [fsge_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fsge_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // Grid geometry. Cells are addressed as {bank, row, col}, so the memory
  // holds a power-of-two span per bank and no multiplier forms addresses.
  localparam int CW  = $clog2(GRID_COLS);
  localparam int RW  = $clog2(GRID_ROWS);
  localparam int GA  = CW + RW;
  localparam int AW  = GA + 1;
  localparam int MW0 = (CW > RW) ? CW : RW;
  localparam int MW1 = (MW0 > 7) ? MW0 : 7;
  // Signed coordinate width: covers brush offsets and the grid edge.
  localparam int SW  = MW1 + 2;

  typedef enum logic [15:0] {
    ST_CLEAR    = 16'b0000_0000_0000_0001,
    ST_IDLE     = 16'b0000_0000_0000_0010,
    ST_RD_ISSUE = 16'b0000_0000_0000_0100,
    ST_RD_WAIT  = 16'b0000_0000_0000_1000,
    ST_PAINT    = 16'b0000_0000_0001_0000,
    ST_COPY     = 16'b0000_0000_0010_0000,
    ST_ROW      = 16'b0000_0000_0100_0000,
    ST_CELL_RD  = 16'b0000_0000_1000_0000,
    ST_CELL_CHK = 16'b0000_0001_0000_0000,
    ST_TRY      = 16'b0000_0010_0000_0000,
    ST_TRY_CHK  = 16'b0000_0100_0000_0000,
    ST_PASS_CHK = 16'b0000_1000_0000_0000,
    ST_WR_TGT   = 16'b0001_0000_0000_0000,
    ST_WR_CUR   = 16'b0010_0000_0000_0000,
    ST_NEXT     = 16'b0100_0000_0000_0000,
    ST_DONE     = 16'b1000_0000_0000_0000
  } state_e;

  // Candidate targets of a moving cell, in the order they are tried.
  typedef enum logic [2:0] {
    TRY_BELOW  = 3'd0,
    TRY_DIAG0  = 3'd1,
    TRY_DIAG1  = 3'd2,
    TRY_SIDE1A = 3'd3,
    TRY_SIDE1B = 3'd4,
    TRY_SIDE2A = 3'd5,
    TRY_SIDE2B = 3'd6
  } try_e;

  state_e state_q, state_d;
  try_e   try_q, try_d;

  // Configuration.
  logic [fsge_pkg::BRUSH_W-1:0] brush_size_q;
  logic [1:0]                   brush_mat_q;

  // Item and result registers.
  logic [1:0]                   cmd_q, cmd_d;
  logic [fsge_pkg::COORD_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [1:0]                   res_mat_q, res_mat_d;
  logic                         out_valid_q, out_valid_d;
  logic [1:0]                   out_mat_q, out_mat_d;
  logic                         out_read_q, out_read_d;

  // Sequencer registers.
  logic          live_q, live_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic signed [5:0] dx_q, dx_d, dy_q, dy_d;
  logic [RW-1:0] y_q, y_d;
  logic [CW-1:0] i_q, i_d;
  logic          asc_q, asc_d, dir_q, dir_d, side_q, side_d;
  logic [1:0]    mat_q, mat_d, tgt_val_q, tgt_val_d;
  logic [CW-1:0] tx_q, tx_d;
  logic [RW-1:0] ty_q, ty_d;

  // Grid memory: both banks in one array, one write and one read port.
  logic [1:0]    mem [2**AW];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [1:0]    mem_wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Random bits.
  fsge_pkg::rng_ctrl_t rng_ctrl;
  logic                rng_bit;
  logic                draw;

  assign rng_ctrl.load = cfg_we_i && (cfg_index_i == fsge_pkg::CFG_RANDOM_SEED);
  assign rng_ctrl.seed = cfg_data_i;
  assign rng_ctrl.draw = draw;

  fsge_lfsr u_lfsr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rng_ctrl),
    .bit_o  (rng_bit)
  );

  // Brush geometry: one point of the brush square per cycle.
  logic signed [SW-1:0] cx_s, cy_s, px_s, py_s;
  logic signed [5:0]    r_s;
  logic signed [11:0]   dx2, dy2, r2;
  logic signed [12:0]   dist2;
  logic                 paint_hit;

  assign cx_s  = $signed({{(SW-fsge_pkg::COORD_W){1'b0}}, cx_q});
  assign cy_s  = $signed({{(SW-fsge_pkg::COORD_W){1'b0}}, cy_q});
  assign px_s  = cx_s + $signed({{(SW-6){dx_q[5]}}, dx_q});
  assign py_s  = cy_s + $signed({{(SW-6){dy_q[5]}}, dy_q});
  assign r_s   = $signed({2'b00, brush_size_q});
  assign dx2   = dx_q * dx_q;
  assign dy2   = dy_q * dy_q;
  assign r2    = r_s * r_s;
  assign dist2 = {dx2[11], dx2} + {dy2[11], dy2};
  assign paint_hit = (px_s >= 0) && (px_s < $signed(SW'(GRID_COLS))) &&
                     (py_s >= 0) && (py_s < $signed(SW'(GRID_ROWS))) &&
                     (dist2 <= {r2[11], r2});

  logic rd_in_grid;
  assign rd_in_grid = (cx_s < $signed(SW'(GRID_COLS))) &&
                      (cy_s < $signed(SW'(GRID_ROWS)));

  // Sweep position and the candidate target of the current try.
  logic [CW-1:0]        x_c;
  logic signed [SW-1:0] xs, ys, tx_s, ty_s, pass_s;
  logic signed [2:0]    off;
  logic signed [2:0]    half_off;
  logic                 down, tgt_ok;

  assign x_c = asc_q ? i_q : (CW'(GRID_COLS - 1) - i_q);
  assign xs  = $signed({{(SW-CW){1'b0}}, x_c});
  assign ys  = $signed({{(SW-RW){1'b0}}, y_q});

  always_comb begin
    off  = 3'sd0;
    down = 1'b0;
    case (try_q)
      TRY_BELOW:  begin off = 3'sd0;                    down = 1'b1; end
      TRY_DIAG0:  begin off = dir_q ? -3'sd1 : 3'sd1;   down = 1'b1; end
      TRY_DIAG1:  begin off = dir_q ? 3'sd1 : -3'sd1;   down = 1'b1; end
      TRY_SIDE1A: off = side_q ? 3'sd1 : -3'sd1;
      TRY_SIDE1B: off = side_q ? -3'sd1 : 3'sd1;
      TRY_SIDE2A: off = side_q ? 3'sd2 : -3'sd2;
      TRY_SIDE2B: off = side_q ? -3'sd2 : 3'sd2;
      default:    off = 3'sd0;
    endcase
  end

  assign half_off = off >>> 1;
  assign tx_s     = xs + $signed({{(SW-3){off[2]}}, off});
  assign ty_s     = ys + $signed(SW'(down));
  assign pass_s   = xs + $signed({{(SW-3){half_off[2]}}, half_off});
  assign tgt_ok   = (tx_s >= 0) && (tx_s < $signed(SW'(GRID_COLS))) &&
                    (ty_s < $signed(SW'(GRID_ROWS)));

  // What follows a failed try: the next candidate, a draw, or the end.
  try_e adv_try;
  logic adv_dir, adv_side, adv_end;

  always_comb begin
    adv_try  = try_q;
    adv_dir  = 1'b0;
    adv_side = 1'b0;
    adv_end  = 1'b0;
    case (try_q)
      TRY_BELOW: begin
        adv_try = TRY_DIAG0;
        adv_dir = 1'b1;
      end
      TRY_DIAG0: adv_try = TRY_DIAG1;
      TRY_DIAG1: begin
        // Sand stops after the diagonals; water goes on sideways.
        if (mat_q == fsge_pkg::CELL_SAND) begin
          adv_end = 1'b1;
        end else begin
          adv_try  = TRY_SIDE1A;
          adv_side = 1'b1;
        end
      end
      TRY_SIDE1A: adv_try = TRY_SIDE1B;
      TRY_SIDE1B: adv_try = TRY_SIDE2A;
      TRY_SIDE2A: adv_try = TRY_SIDE2B;
      TRY_SIDE2B: adv_end = 1'b1;
      default:    adv_end = 1'b1;
    endcase
  end

  logic tgt_free;
  assign tgt_free = (rdata_q == fsge_pkg::CELL_EMPTY) ||
                    ((mat_q == fsge_pkg::CELL_SAND) && (rdata_q == fsge_pkg::CELL_WATER));

  // Main sequencer.
  always_comb begin
    state_d     = state_q;
    try_d       = try_q;
    cmd_d       = cmd_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    res_mat_d   = res_mat_q;
    out_valid_d = out_valid_q;
    out_mat_d   = out_mat_q;
    out_read_d  = out_read_q;
    live_d      = live_q;
    cnt_d       = cnt_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    y_d         = y_q;
    i_d         = i_q;
    asc_d       = asc_q;
    dir_d       = dir_q;
    side_d      = side_q;
    mat_d       = mat_q;
    tgt_val_d   = tgt_val_q;
    tx_d        = tx_q;
    ty_d        = ty_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = fsge_pkg::CELL_EMPTY;
    mem_raddr   = '0;
    draw        = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == {AW{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = command_i;
          cx_d      = col_i;
          cy_d      = row_i;
          res_mat_d = fsge_pkg::CELL_EMPTY;
          dx_d      = -r_s;
          dy_d      = -r_s;
          cnt_d     = '0;
          case (command_i)
            fsge_pkg::CMD_PAINT: state_d = ST_PAINT;
            fsge_pkg::CMD_STEP:  state_d = ST_COPY;
            fsge_pkg::CMD_READ:  state_d = ST_RD_ISSUE;
            default:             state_d = ST_DONE;
          endcase
        end
      end

      ST_RD_ISSUE: begin
        mem_raddr = {live_q, cy_s[RW-1:0], cx_s[CW-1:0]};
        state_d   = ST_RD_WAIT;
      end

      ST_RD_WAIT: begin
        res_mat_d = rd_in_grid ? rdata_q : fsge_pkg::CELL_EMPTY;
        state_d   = ST_DONE;
      end

      ST_PAINT: begin
        mem_we    = paint_hit;
        mem_waddr = {live_q, py_s[RW-1:0], px_s[CW-1:0]};
        mem_wdata = brush_mat_q;
        if (dx_q == r_s) begin
          dx_d = -r_s;
          if (dy_q == r_s) begin
            state_d = ST_DONE;
          end else begin
            dy_d = dy_q + 6'sd1;
          end
        end else begin
          dx_d = dx_q + 6'sd1;
        end
      end

      ST_COPY: begin
        // Read cell k of the live bank while cell k-1 lands in the other.
        mem_raddr = {live_q, cnt_q[GA-1:0]};
        mem_we    = (cnt_q != '0);
        mem_waddr = {~live_q, GA'(cnt_q - AW'(1))};
        mem_wdata = rdata_q;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q[GA]) begin
          y_d     = RW'(GRID_ROWS - 1);
          state_d = ST_ROW;
        end
      end

      ST_ROW: begin
        draw    = 1'b1;
        asc_d   = rng_bit;
        i_d     = '0;
        state_d = ST_CELL_RD;
      end

      ST_CELL_RD: begin
        mem_raddr = {live_q, y_q, x_c};
        state_d   = ST_CELL_CHK;
      end

      ST_CELL_CHK: begin
        if ((rdata_q == fsge_pkg::CELL_SAND) || (rdata_q == fsge_pkg::CELL_WATER)) begin
          mat_d   = rdata_q;
          try_d   = TRY_BELOW;
          state_d = ST_TRY;
        end else begin
          state_d = ST_NEXT;
        end
      end

      ST_TRY: begin
        tx_d = tx_s[CW-1:0];
        ty_d = ty_s[RW-1:0];
        if (tgt_ok) begin
          mem_raddr = {~live_q, ty_s[RW-1:0], tx_s[CW-1:0]};
          state_d   = ST_TRY_CHK;
        end else begin
          draw    = adv_dir || adv_side;
          dir_d   = adv_dir ? rng_bit : dir_q;
          side_d  = adv_side ? rng_bit : side_q;
          try_d   = adv_try;
          state_d = adv_end ? ST_NEXT : ST_TRY;
        end
      end

      ST_TRY_CHK: begin
        tgt_val_d = rdata_q;
        if (tgt_free) begin
          if ((try_q == TRY_SIDE2A) || (try_q == TRY_SIDE2B)) begin
            // The cell passed over must be empty or water.
            mem_raddr = {~live_q, y_q, pass_s[CW-1:0]};
            state_d   = ST_PASS_CHK;
          end else begin
            state_d = ST_WR_TGT;
          end
        end else begin
          draw    = adv_dir || adv_side;
          dir_d   = adv_dir ? rng_bit : dir_q;
          side_d  = adv_side ? rng_bit : side_q;
          try_d   = adv_try;
          state_d = adv_end ? ST_NEXT : ST_TRY;
        end
      end

      ST_PASS_CHK: begin
        if ((rdata_q == fsge_pkg::CELL_EMPTY) || (rdata_q == fsge_pkg::CELL_WATER)) begin
          state_d = ST_WR_TGT;
        end else begin
          try_d   = adv_try;
          state_d = adv_end ? ST_NEXT : ST_TRY;
        end
      end

      ST_WR_TGT: begin
        mem_we    = 1'b1;
        mem_waddr = {~live_q, ty_q, tx_q};
        mem_wdata = mat_q;
        state_d   = ST_WR_CUR;
      end

      ST_WR_CUR: begin
        // Sand trades places with water; otherwise the cell left is empty.
        mem_we    = 1'b1;
        mem_waddr = {~live_q, y_q, x_c};
        mem_wdata = tgt_val_q;
        state_d   = ST_NEXT;
      end

      ST_NEXT: begin
        if (i_q == CW'(GRID_COLS - 1)) begin
          if (y_q == '0) begin
            live_d  = ~live_q;
            state_d = ST_DONE;
          end else begin
            y_d     = y_q - RW'(1);
            state_d = ST_ROW;
          end
        end else begin
          i_d     = i_q + CW'(1);
          state_d = ST_CELL_RD;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_mat_d   = res_mat_q;
          out_read_d  = (cmd_q == fsge_pkg::CMD_READ);
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      try_q        <= TRY_BELOW;
      cnt_q        <= '0;
      live_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      brush_size_q <= fsge_pkg::BRUSH_SIZE_RESET;
      brush_mat_q  <= fsge_pkg::CELL_SAND;
    end else begin
      state_q     <= state_d;
      try_q       <= try_d;
      cnt_q       <= cnt_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_index_i == fsge_pkg::CFG_BRUSH_SIZE)) begin
        brush_size_q <= cfg_data_i[fsge_pkg::BRUSH_W-1:0];
      end
      if (cfg_we_i && (cfg_index_i == fsge_pkg::CFG_BRUSH_MATERIAL)) begin
        brush_mat_q <= cfg_data_i[1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    res_mat_q <= res_mat_d;
    out_mat_q <= out_mat_d;
    out_read_q <= out_read_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    y_q       <= y_d;
    i_q       <= i_d;
    asc_q     <= asc_d;
    dir_q     <= dir_d;
    side_q    <= side_d;
    mat_q     <= mat_d;
    tgt_val_q <= tgt_val_d;
    tx_q      <= tx_d;
    ty_q      <= ty_d;
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign cell_material_o = out_mat_q;
  assign was_read_o      = out_read_q;

  // An accepted item always leaves the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input transfer did not start work");

  // The grid is never written while the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("grid write while idle");

  // The banks swap only at the end of a sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(live_q) |-> $past(state_q == ST_NEXT))
    else $error("bank swap outside the sweep end");

  // A result appears only from the done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result without a finished item");

endmodule

>>> rtl/fsge_lfsr.sv
// ----------------------------------------------------------------------------
// Falling sand random bit generator
// 16-bit Fibonacci LFSR, taps 16, 14, 13, 11; one bit per draw.
// ----------------------------------------------------------------------------
module fsge_lfsr (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fsge_pkg::rng_ctrl_t   ctrl_i,
  output logic                  bit_o
);

  logic [fsge_pkg::RNG_W-1:0] state_q, state_d;

  assign bit_o = state_q[0] ^ state_q[2] ^ state_q[3] ^ state_q[5];

  always_comb begin
    state_d = state_q;
    if (ctrl_i.load) begin
      // A zero seed would lock the register, so it loads one instead.
      state_d = (ctrl_i.seed == '0) ? fsge_pkg::RNG_W'(1) : ctrl_i.seed;
    end else if (ctrl_i.draw) begin
      state_d = {bit_o, state_q[fsge_pkg::RNG_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsge_pkg::RNG_SEED_RESET;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
